// ----- rtl/core/aes_enc_pkg.sv -----
package aes_enc_pkg;

   localparam int unsigned MAX_ROUND_KEYS_DEF = 15;
   localparam logic [3:0] ROUND_COUNT_RESET = 4'd10;
   // slot numbers run up to one past the last slot of a 15-round item
   localparam int unsigned SLOT_W = 5;
   localparam logic [7:0] GF_POLY = 8'h1b;

   localparam logic REQ_KEY_LOAD = 1'b0;
   localparam logic REQ_ENCRYPT  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [3:0]  key_index;
      logic [63:0] data_low;
      logic [63:0] data_high;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] cipher_low;
      logic [63:0] cipher_high;
   } rsp_payload_type;

   localparam logic [7:0] SBOX_TABLE [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   // byte 4*row+col sits in bits 8*(4*row+col) +: 8
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      logic [1:0]   src_col;
      t = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            src_col = 2'(c + r);
            t[8*(4*r+c) +: 8] = SBOX_TABLE[s[8*(4*r+int'(src_col)) +: 8]];
         end
      end
      sub_shift = t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, d0, d1, d2, d3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[8*c +: 8];
         a1 = s[8*(4+c) +: 8];
         a2 = s[8*(8+c) +: 8];
         a3 = s[8*(12+c) +: 8];
         d0 = xtime(a0);
         d1 = xtime(a1);
         d2 = xtime(a2);
         d3 = xtime(a3);
         t[8*c +: 8]      = d0 ^ d1 ^ a1 ^ a2 ^ a3;
         t[8*(4+c) +: 8]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
         t[8*(8+c) +: 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
         t[8*(12+c) +: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
      end
      mix_columns = t;
   endfunction

endpackage

// ----- rtl/core/aes_block_encrypt.sv -----
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// request   | req_valid / req_stall  | req_payload: req_type, key_index, data
// response  | rsp_valid / rsp_stall  | rsp_payload: cipher_low, cipher_high
// csr       | csr_wr_en              | csr_wr_data: round_count
//
// A key load writes the key store when accepted; an index past the store is dropped.
// An encrypt item does the first key add, then one round per cycle through the shared
// round unit, a stalled response holding the last round until the output register is
// free; round keys come from the key store one slot ahead through its registered read.
// Reset is synchronous and sets round_count to 10; the key store is not cleared.
module aes_block_encrypt #(
   parameter int unsigned MAX_ROUND_KEYS = aes_enc_pkg::MAX_ROUND_KEYS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  aes_enc_pkg::req_payload_type req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output aes_enc_pkg::rsp_payload_type rsp_payload,
   input  logic                         csr_wr_en,
   input  logic [3:0]                   csr_wr_data
);

   localparam int unsigned KEY_IDX_W = $clog2(MAX_ROUND_KEYS);
   localparam int unsigned SLOT_W    = aes_enc_pkg::SLOT_W;
   localparam logic [SLOT_W-1:0] KEY_DEPTH = SLOT_W'(MAX_ROUND_KEYS);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ADDKEY = 3'b010,
      ST_ROUND  = 3'b100
   } fsm_type;

   fsm_type      st_ff, st_in;
   logic [3:0]   round_cnt_ff;
   logic [3:0]   slot_ff, slot_in;
   logic [127:0] state_ff, state_in;
   logic [127:0] key_q_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   aes_enc_pkg::rsp_payload_type rsp_data_ff;

   logic [127:0] key_store [MAX_ROUND_KEYS];

   logic               accept, accept_key, accept_enc;
   logic [3:0]         last_slot;
   logic               last_round, finish, key_adv;
   logic [SLOT_W-1:0]  rd_addr;
   logic [127:0]       shifted, round_out;

   assign req_stall  = (st_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign accept_key = accept && (req_payload.req_type == aes_enc_pkg::REQ_KEY_LOAD);
   assign accept_enc = accept && (req_payload.req_type == aes_enc_pkg::REQ_ENCRYPT);

   // a round count of zero runs as one round
   assign last_slot  = (round_cnt_ff == 4'd0) ? 4'd1 : round_cnt_ff;
   assign last_round = (slot_ff == last_slot);
   assign finish     = (st_ff == ST_ROUND) && last_round && !(rsp_valid_ff && rsp_stall);

   assign shifted   = aes_enc_pkg::sub_shift(state_ff);
   assign round_out = (last_round ? shifted : aes_enc_pkg::mix_columns(shifted)) ^ key_q_ff;

   // fetch the key for the next slot; advance only when the round moves on
   assign rd_addr = (st_ff == ST_IDLE) ? '0 : ({1'b0, slot_ff} + SLOT_W'(1));
   assign key_adv = accept_enc || (st_ff == ST_ADDKEY) || ((st_ff == ST_ROUND) && !last_round);

   always_ff @(posedge clock) begin
      if (accept_key && ({1'b0, req_payload.key_index} < KEY_DEPTH)) begin
         key_store[req_payload.key_index[KEY_IDX_W-1:0]] <=
            {req_payload.data_high, req_payload.data_low};
      end
      if (key_adv) begin
         key_q_ff <= (rd_addr < KEY_DEPTH) ? key_store[rd_addr[KEY_IDX_W-1:0]] : '0;
      end
   end

   always_comb begin
      st_in        = st_ff;
      slot_in      = slot_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept_enc) begin
               state_in = {req_payload.data_high, req_payload.data_low};
               slot_in  = 4'd0;
               st_in    = ST_ADDKEY;
            end
         end
         ST_ADDKEY: begin
            state_in = state_ff ^ key_q_ff;
            slot_in  = 4'd1;
            st_in    = ST_ROUND;
         end
         ST_ROUND: begin
            if (!last_round) begin
               state_in = round_out;
               slot_in  = slot_ff + 4'd1;
            end else if (finish) begin
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         round_cnt_ff <= aes_enc_pkg::ROUND_COUNT_RESET;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            round_cnt_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      state_ff <= state_in;
      if (finish) begin
         rsp_data_ff.cipher_low  <= round_out[63:0];
         rsp_data_ff.cipher_high <= round_out[127:64];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ----- bench/aes_block_encrypt_tb.sv -----
module aes_block_encrypt_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 7;
   localparam int KEY_SLOTS        = aes_enc_pkg::MAX_ROUND_KEYS_DEF;
   localparam int KEY_LOAD_SETTLE  = 4;
   localparam int DRAIN_CYCLES     = 24;
   localparam int RSP_HOLD_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SEG_ITEMS        = 238;
   localparam int LOAD_PCT         = 20;

   typedef enum logic [1:0] {ROW_KEY, ROW_ENC, ROW_CFG} row_kind_type;

   // for ROW_CFG the index column carries the round count
   typedef struct packed {
      row_kind_type kind;
      logic [3:0]   index;
      logic [63:0]  lo;
      logic [63:0]  hi;
   } dir_row_type;

   localparam int DIR_ROWS = 30;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{ROW_KEY, 4'd0,  64'h0000000000000000, 64'h0000000000000000},
      '{ROW_KEY, 4'd1,  64'hffffffffffffffff, 64'hffffffffffffffff},
      '{ROW_KEY, 4'd2,  64'h5555555555555555, 64'haaaaaaaaaaaaaaaa},
      '{ROW_KEY, 4'd3,  64'haaaaaaaaaaaaaaaa, 64'h5555555555555555},
      '{ROW_KEY, 4'd4,  64'h0123456789abcdef, 64'hfedcba9876543210},
      '{ROW_KEY, 4'd5,  64'h8000000000000000, 64'h0000000000000001},
      '{ROW_KEY, 4'd6,  64'h0000000000000001, 64'h8000000000000000},
      '{ROW_KEY, 4'd7,  64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0},
      '{ROW_KEY, 4'd8,  64'h3c5a96e1d2b4780f, 64'h0b1c2d3e4f506172},
      '{ROW_KEY, 4'd9,  64'h1111111111111111, 64'h2222222222222222},
      '{ROW_KEY, 4'd10, 64'h3333333333333333, 64'h4444444444444444},
      '{ROW_KEY, 4'd11, 64'h6666666666666666, 64'h7777777777777777},
      '{ROW_KEY, 4'd12, 64'h8888888888888888, 64'h9999999999999999},
      '{ROW_KEY, 4'd13, 64'hbbbbbbbbbbbbbbbb, 64'hcccccccccccccccc},
      '{ROW_KEY, 4'd14, 64'hdddddddddddddddd, 64'heeeeeeeeeeeeeeee},
      // slot past the store: the load must be dropped
      '{ROW_KEY, 4'd15, 64'hffffffffffffffff, 64'hffffffffffffffff},
      '{ROW_ENC, 4'd0,  64'h0000000000000000, 64'h0000000000000000},
      '{ROW_ENC, 4'd15, 64'hffffffffffffffff, 64'hffffffffffffffff},
      '{ROW_ENC, 4'd5,  64'h0011223344556677, 64'h8899aabbccddeeff},
      // zero rounds acts as a single final round
      '{ROW_CFG, 4'd0,  64'h0, 64'h0},
      '{ROW_ENC, 4'd0,  64'h5555555555555555, 64'haaaaaaaaaaaaaaaa},
      '{ROW_CFG, 4'd1,  64'h0, 64'h0},
      '{ROW_ENC, 4'd9,  64'h8000000000000001, 64'h7ffffffffffffffe},
      // fifteen rounds: the last round key lies beyond the store and reads as zero
      '{ROW_CFG, 4'd15, 64'h0, 64'h0},
      '{ROW_ENC, 4'd3,  64'h00000000ffffffff, 64'hffffffff00000000},
      '{ROW_CFG, 4'd14, 64'h0, 64'h0},
      '{ROW_ENC, 4'd12, 64'h0123456789abcdef, 64'h0123456789abcdef},
      '{ROW_CFG, 4'd12, 64'h0, 64'h0},
      '{ROW_ENC, 4'd7,  64'hffffffffffffffff, 64'h0000000000000000},
      '{ROW_CFG, 4'd10, 64'h0, 64'h0}
   };

   localparam logic [3:0] SEG_ROUNDS [6] = '{4'd10, 4'd0, 4'd14, 4'd1, 4'd15, 4'd12};
   localparam int unsigned SEND_IDLE [3] = '{27, 58, 0};
   localparam int unsigned RECV_IDLE [3] = '{58, 27, 0};

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   aes_enc_pkg::req_payload_type req_payload;
   logic                         rsp_valid;
   logic                         rsp_stall;
   aes_enc_pkg::rsp_payload_type rsp_payload;
   logic                         csr_wr_en;
   logic [3:0]                   csr_wr_data;

   // predictor state
   logic [7:0]                   sbox_lut [256];
   logic [127:0]                 key_slots [KEY_SLOTS];
   logic [3:0]                   rounds_cfg;
   aes_enc_pkg::rsp_payload_type expected_ciphers [$];

   int unsigned     req_idle_pct = 0;
   int unsigned     rsp_idle_pct = 0;
   bit              rsp_hold_req = 1'b0;
   int              error_count = 0;
   int              idle_cycles = 0;
   int              key_load_count = 0;
   int              encrypt_count = 0;
   int              checked_count = 0;
   logic [15:0]     rounds_seen = '0;

   aes_block_encrypt uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] term;
      acc  = 8'h00;
      term = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= term;
         term = gf_double(term);
      end
      return acc;
   endfunction

   // build the S-box from the field inverse and the affine map
   initial begin : sbox_build
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
         end
         sbox_lut[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                       ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   end

   // state byte 4*row+col lives in bits 8*(4*row+col) +: 8
   function automatic logic [127:0] sub_bytes_shift_rows(input logic [127:0] s);
      logic [127:0] t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[8*(4*r+c) +: 8] = sbox_lut[s[8*(4*r+((c+r)%4)) +: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0  = s[8*c +: 8];
         a1  = s[8*(4+c) +: 8];
         a2  = s[8*(8+c) +: 8];
         a3  = s[8*(12+c) +: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[8*c +: 8]      = a0 ^ all ^ gf_double(a0 ^ a1);
         t[8*(4+c) +: 8]  = a1 ^ all ^ gf_double(a1 ^ a2);
         t[8*(8+c) +: 8]  = a2 ^ all ^ gf_double(a2 ^ a3);
         t[8*(12+c) +: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
      end
      return t;
   endfunction

   function automatic logic [127:0] round_key(input int slot);
      return (slot < KEY_SLOTS) ? key_slots[slot] : 128'h0;
   endfunction

   function automatic aes_enc_pkg::rsp_payload_type predict_cipher(input logic [63:0] lo,
                                                                   input logic [63:0] hi);
      logic [127:0]                 s;
      int                           slot;
      aes_enc_pkg::rsp_payload_type res;
      s    = {hi, lo} ^ round_key(0);
      slot = 1;
      for (int r = int'(rounds_cfg); r > 1; r--) begin
         s = mix_cols(sub_bytes_shift_rows(s)) ^ round_key(slot);
         slot++;
      end
      s = sub_bytes_shift_rows(s) ^ round_key(slot);
      res.cipher_low  = s[63:0];
      res.cipher_high = s[127:64];
      return res;
   endfunction

   function automatic logic [63:0] rand_word();
      case ($urandom_range(15))
         0:       return 64'h0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // track what the block accepts and check what it returns
   always @(posedge clock) begin : track_and_check
      aes_enc_pkg::rsp_payload_type want;
      logic                         moved;
      moved = 1'b0;
      if (reset) begin
         rounds_cfg = aes_enc_pkg::ROUND_COUNT_RESET;
      end else begin
         if (csr_wr_en) rounds_cfg = csr_wr_data;
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            if (req_payload.req_type == aes_enc_pkg::REQ_ENCRYPT) begin
               expected_ciphers.push_back(predict_cipher(req_payload.data_low,
                                                         req_payload.data_high));
               encrypt_count++;
            end else begin
               if (req_payload.key_index < KEY_SLOTS)
                  key_slots[req_payload.key_index] = {req_payload.data_high,
                                                      req_payload.data_low};
               key_load_count++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_ciphers.size() == 0) begin
               $error("unexpected result: cipher_low %h cipher_high %h",
                      rsp_payload.cipher_low, rsp_payload.cipher_high);
               error_count++;
            end else begin
               want = expected_ciphers.pop_front();
               checked_count++;
               if (rsp_payload.cipher_low !== want.cipher_low) begin
                  $error("cipher_low: expected %h, got %h",
                         want.cipher_low, rsp_payload.cipher_low);
                  error_count++;
               end
               if (rsp_payload.cipher_high !== want.cipher_high) begin
                  $error("cipher_high: expected %h, got %h",
                         want.cipher_high, rsp_payload.cipher_high);
                  error_count++;
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin : rsp_side
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   task automatic offer_item(input aes_enc_pkg::req_payload_type item);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and wait until every pending result is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_ciphers.size() != 0) @(posedge clock);
      repeat (KEY_LOAD_SETTLE) @(posedge clock);
   endtask

   task automatic write_rounds(input logic [3:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      rounds_seen[value] = 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : req_side
      aes_enc_pkg::req_payload_type item;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      rounds_seen[aes_enc_pkg::ROUND_COUNT_RESET] = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TABLE[i]) begin
         if (DIR_TABLE[i].kind == ROW_CFG) begin
            wait_idle();
            write_rounds(DIR_TABLE[i].index);
         end else begin
            item.req_type  = (DIR_TABLE[i].kind == ROW_ENC) ? aes_enc_pkg::REQ_ENCRYPT
                                                            : aes_enc_pkg::REQ_KEY_LOAD;
            item.key_index = DIR_TABLE[i].index;
            item.data_low  = DIR_TABLE[i].lo;
            item.data_high = DIR_TABLE[i].hi;
            offer_item(item);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         req_idle_pct = SEND_IDLE[ph];
         rsp_idle_pct = RECV_IDLE[ph];
         for (int seg = 0; seg < 2; seg++) begin
            wait_idle();
            write_rounds(SEG_ROUNDS[2*ph + seg]);
            for (int k = 0; k < SEG_ITEMS; k++) begin
               // long receiver hold-off while items keep coming
               if (ph == 2 && seg == 0 && k == 60) rsp_hold_req = 1'b1;
               // sender pause until the pipe is empty
               if (seg == 1 && k == 150) wait_idle();
               item.req_type  = ($urandom_range(99) < LOAD_PCT) ? aes_enc_pkg::REQ_KEY_LOAD
                                                                 : aes_enc_pkg::REQ_ENCRYPT;
               item.key_index = 4'($urandom_range(15));
               item.data_low  = rand_word();
               item.data_high = rand_word();
               offer_item(item);
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d key loads and %0d encryptions, %0d ciphertexts checked,",
               key_load_count, encrypt_count, checked_count);
      $display("over round counts %b (bit n = n rounds) with stalls on either side.",
               rounds_seen);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
